// ===== sv/sorted_key_run_index_builder_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Run index builder: assertion macros
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_RUN_INDEX_BUILDER_UNIT_DEFINES_SVH
`define SORTED_KEY_RUN_INDEX_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SKRIB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SKRIB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/skrib_pkg.sv =====
// ---------------------------------------------------------------------------
// Run index builder package
// Shared constants, result kinds and the command and result records.
// ---------------------------------------------------------------------------
package skrib_pkg;

	localparam int MAX_RUN_DEF      = 32;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int CFG_W            = 6;
	localparam int WORD_W           = 32;
	localparam int CMD_Q_DEPTH      = 2;
	localparam int RES_Q_DEPTH      = 2;

	localparam logic [CFG_W-1:0] MAX_REPEATS_RST = 6'd32;

	typedef enum logic [1:0] {
		KIND_KEY      = 2'd0,
		KIND_RECORD   = 2'd1,
		KIND_SENTINEL = 2'd2
	} kind_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic              close_first;
		logic              take;
		logic              eop;
		logic [WORD_W-1:0] seed;
		logic [WORD_W-1:0] payload;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] key_or_seed;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] record_payload;
		logic [WORD_W-1:0] kept_keys;
		logic [WORD_W-1:0] dropped_runs;
		logic              last_of_burst;
	} res_t;

endpackage

// ===== sv/sorted_key_run_index_builder_unit.sv =====
// ---------------------------------------------------------------------------
// Sorted key run index builder
// Groups runs of equal seeds, filters overlong runs and emits key, record
// and partition sentinel results.
// ---------------------------------------------------------------------------
// Channel   Handshake          Fields
// input     push / full        has_record, seed, payload, end_of_partition
// result    pop / empty        kind, key_or_seed, offset, record_payload,
//                              kept_keys, dropped_runs, last_of_burst
// config    cfg_wr_en          cfg_wr_data -> max_repeats
//
// A record is dispatched and then written to the run buffer; a bare end marker
// is only dispatched, and an end of partition adds a run close and a sentinel.
// A close of a kept run emits the key, then for each of its records does a
// registered buffer read and an emit; a dropped run is closed without output.
// Reset clears control state and counters; the run buffer needs no sweep.
// Full follows the command queue; a full result queue stalls the back end.
// ---------------------------------------------------------------------------
module sorted_key_run_index_builder_unit import skrib_pkg::*; #(
	parameter int MAX_RUN      = MAX_RUN_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              has_record,
	input  logic [WORD_W-1:0] seed,
	input  logic [WORD_W-1:0] payload,
	input  logic              end_of_partition,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        kind,
	output logic [WORD_W-1:0] key_or_seed,
	output logic [WORD_W-1:0] offset,
	output logic [WORD_W-1:0] record_payload,
	output logic [WORD_W-1:0] kept_keys,
	output logic [WORD_W-1:0] dropped_runs,
	output logic              last_of_burst,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data
);

	logic [CFG_W-1:0] max_repeats_q;
	logic             cmd_push;
	logic             cmd_full;
	logic             cmd_empty;
	logic             cmd_pop;
	cmd_t             cmd_in;
	cmd_t             cmd_out;
	logic             res_push;
	logic             res_full;
	res_t             res_in;
	res_t             res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repeats_q <= MAX_REPEATS_RST;
		end else if (cfg_wr_en) begin
			max_repeats_q <= cfg_wr_data;
		end
	end

	skrib_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.has_record       (has_record),
		.seed             (seed),
		.payload          (payload),
		.end_of_partition (end_of_partition),
		.cmd_full         (cmd_full),
		.cmd_push         (cmd_push),
		.cmd              (cmd_in)
	);

	skrib_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_Q_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	skrib_back #(
		.MAX_RUN      (MAX_RUN),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_repeats (max_repeats_q),
		.cmd_valid   (!cmd_empty),
		.cmd         (cmd_out),
		.cmd_pop     (cmd_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res_in)
	);

	skrib_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign kind           = res_out.kind;
	assign key_or_seed    = res_out.key_or_seed;
	assign offset         = res_out.offset;
	assign record_payload = res_out.record_payload;
	assign kept_keys      = res_out.kept_keys;
	assign dropped_runs   = res_out.dropped_runs;
	assign last_of_burst  = res_out.last_of_burst;

endmodule

// ===== sv/skrib_ram.sv =====
// ---------------------------------------------------------------------------
// Run index builder: generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module skrib_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/skrib_fifo.sv =====
// ---------------------------------------------------------------------------
// Run index builder: small queue
// Flop-based first-in first-out queue, head shown while not empty.
// ---------------------------------------------------------------------------
module skrib_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/skrib_front.sv =====
// ---------------------------------------------------------------------------
// Run index builder: front end
// Takes items, drops idle ones and marks where a new seed closes a run.
// ---------------------------------------------------------------------------
module skrib_front import skrib_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              has_record,
	input  logic [WORD_W-1:0] seed,
	input  logic [WORD_W-1:0] payload,
	input  logic              end_of_partition,
	input  logic              cmd_full,
	output logic              cmd_push,
	output cmd_t              cmd
);

	// Copy of the back end's run state, ahead of it by the queued commands.
	logic              open_q;
	logic [WORD_W-1:0] seed_q;
	logic              accept;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign cmd_push = accept && (has_record || end_of_partition);

	always_comb begin
		cmd.close_first = has_record && open_q && (seed != seed_q);
		cmd.take        = has_record;
		cmd.eop         = end_of_partition;
		cmd.seed        = seed;
		cmd.payload     = payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			seed_q <= '0;
		end else if (accept) begin
			if (has_record || end_of_partition) begin
				open_q <= has_record && !end_of_partition;
			end
			if (has_record) begin
				seed_q <= seed;
			end
		end
	end

endmodule

// ===== sv/skrib_back.sv =====
// ---------------------------------------------------------------------------
// Run index builder: back end
// Owns the run buffer and counters, and sequences keys, records and
// sentinels into the result queue.
// ---------------------------------------------------------------------------
module skrib_back import skrib_pkg::*; #(
	parameter int MAX_RUN      = MAX_RUN_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] max_repeats,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output res_t             res
);

	localparam int STORE_W = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
	localparam int AW      = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int LEN_W   = $clog2(MAX_RUN + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLOSE = 7'b0000010,
		ST_KEY   = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_WR    = 7'b0010000,
		ST_TAKE  = 7'b0100000,
		ST_SENT  = 7'b1000000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	state_t            close_next;
	cmd_t              cmd_q;
	logic              late_q;
	logic [WORD_W-1:0] run_seed_q;
	logic [LEN_W-1:0]  run_len_q;
	logic              run_open_q;
	logic              run_too_long_q;
	logic [LEN_W-1:0]  rec_idx_q;
	logic [LEN_W-1:0]  rec_next;
	logic              rec_last;
	logic [WORD_W-1:0] records_q;
	logic [WORD_W-1:0] kept_q;
	logic [WORD_W-1:0] dropped_q;
	logic [CFG_W-1:0]  limit;
	logic [CFG_W:0]    len_p1;
	logic              over_limit;
	logic              ram_we;
	logic              ram_re;
	logic [STORE_W-1:0] ram_rdata;

	assign limit = (max_repeats > CFG_W'(MAX_RUN)) ? CFG_W'(MAX_RUN) : max_repeats;
	assign len_p1 = (CFG_W + 1)'(run_len_q) + (CFG_W + 1)'(1);
	assign over_limit = (len_p1 > {1'b0, limit}) || (run_len_q >= LEN_W'(MAX_RUN));
	assign rec_next = rec_idx_q + LEN_W'(1);
	assign rec_last = (rec_next == run_len_q);
	// The close before a record always leads to taking that record.
	assign close_next = late_q ? ST_SENT : ST_TAKE;

	skrib_ram #(
		.WIDTH (STORE_W),
		.DEPTH (MAX_RUN)
	) u_run_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (run_len_q[AW-1:0]),
		.wdata   (cmd_q.payload[STORE_W-1:0]),
		.re      (ram_re),
		.raddr   (rec_idx_q[AW-1:0]),
		.rdata_q (ram_rdata)
	);

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = (cmd.take && !cmd.close_first) ? ST_TAKE : ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				state_d = (!run_open_q || run_too_long_q) ? close_next : ST_KEY;
			end
			ST_KEY: begin
				if (!res_full) begin
					res_push        = 1'b1;
					res.kind        = KIND_KEY;
					res.key_or_seed = run_seed_q;
					res.offset      = records_q;
					state_d         = ST_RD;
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				if (!res_full) begin
					res_push           = 1'b1;
					res.kind           = KIND_RECORD;
					res.key_or_seed    = run_seed_q;
					res.record_payload = WORD_W'(ram_rdata);
					// Only the last record of a run closed by a new seed ends the
					// burst, and only when no sentinel follows.
					res.last_of_burst  = !late_q && !cmd_q.eop && rec_last;
					state_d            = rec_last ? close_next : ST_RD;
				end
			end
			ST_TAKE: begin
				ram_we  = !run_too_long_q && !over_limit;
				state_d = cmd_q.eop ? ST_CLOSE : ST_IDLE;
			end
			ST_SENT: begin
				if (!res_full) begin
					res_push          = 1'b1;
					res.kind          = KIND_SENTINEL;
					res.offset        = records_q;
					res.kept_keys     = kept_q;
					res.dropped_runs  = dropped_q;
					res.last_of_burst = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cmd_q          <= '0;
			late_q         <= 1'b0;
			run_seed_q     <= '0;
			run_len_q      <= '0;
			run_open_q     <= 1'b0;
			run_too_long_q <= 1'b0;
			rec_idx_q      <= '0;
			records_q      <= '0;
			kept_q         <= '0;
			dropped_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q  <= cmd;
						late_q <= !cmd.take;
					end
				end
				ST_CLOSE: begin
					if (run_open_q && run_too_long_q) begin
						dropped_q      <= dropped_q + WORD_W'(1);
						run_open_q     <= 1'b0;
						run_too_long_q <= 1'b0;
						run_len_q      <= '0;
					end
				end
				ST_KEY: begin
					if (!res_full) begin
						rec_idx_q <= '0;
					end
				end
				ST_WR: begin
					if (!res_full) begin
						if (rec_last) begin
							kept_q         <= kept_q + WORD_W'(1);
							records_q      <= records_q + WORD_W'(run_len_q);
							run_open_q     <= 1'b0;
							run_too_long_q <= 1'b0;
							run_len_q      <= '0;
						end else begin
							rec_idx_q <= rec_next;
						end
					end
				end
				ST_TAKE: begin
					late_q <= 1'b1;
					if (!run_open_q) begin
						run_open_q <= 1'b1;
						run_seed_q <= cmd_q.seed;
					end
					if (!run_too_long_q) begin
						if (over_limit) begin
							run_too_long_q <= 1'b1;
						end else begin
							run_len_q <= run_len_q + LEN_W'(1);
						end
					end
				end
				ST_SENT: begin
					if (!res_full) begin
						records_q <= '0;
						kept_q    <= '0;
						dropped_q <= '0;
					end
				end
				default: begin
					late_q <= late_q;
				end
			endcase
		end
	end

endmodule

// ===== sv/skrib_checker.sv =====
// ---------------------------------------------------------------------------
// Run index builder: port checker
// Watches the result channel for ordering and field rules over time.
// ---------------------------------------------------------------------------
`include "sorted_key_run_index_builder_unit_defines.svh"

module skrib_checker import skrib_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [1:0]        kind,
	input logic [WORD_W-1:0] key_or_seed,
	input logic [WORD_W-1:0] offset,
	input logic [WORD_W-1:0] record_payload,
	input logic [WORD_W-1:0] kept_keys,
	input logic [WORD_W-1:0] dropped_runs,
	input logic              last_of_burst
);

	logic                     at_sentinel;
	logic                     at_key;
	logic                     at_record;
	logic                     totals_zero;
	logic                     waiting;
	logic [5*WORD_W+2:0]      head_bits;

	assign at_sentinel = !empty && (kind == KIND_SENTINEL);
	assign at_key      = !empty && (kind == KIND_KEY);
	assign at_record   = !empty && (kind == KIND_RECORD);
	assign totals_zero = (offset == '0) && (kept_keys == '0) && (dropped_runs == '0);
	assign waiting     = !empty && !pop;
	assign head_bits   = {kind, key_or_seed, offset, record_payload, kept_keys,
		dropped_runs, last_of_burst};

	// A sentinel always closes its transaction burst.
	`SKRIB_ASSERT_IMP(a_sentinel_last, at_sentinel, last_of_burst, "sentinel not last")

	// A key never ends its burst: at least one record of its run follows it.
	`SKRIB_ASSERT_IMP(a_key_not_last, at_key, !last_of_burst, "key marked as last of burst")

	// Records carry no totals or offsets.
	`SKRIB_ASSERT_IMP(a_record_fields, at_record, totals_zero, "record with nonzero totals")

	// A waiting result holds until it is taken.
	`SKRIB_ASSERT_NXT(a_result_held, waiting, !empty && $stable(head_bits), "result changed")

endmodule

bind sorted_key_run_index_builder_unit skrib_checker u_skrib_checker (.*);

// ===== sim/tb_sorted_key_run_index_builder_unit.sv =====
// ---------------------------------------------------------------------------
// Run index builder testbench
// Feeds sorted partitions, broken sequences and idle items through the
// push/full side and checks every key, record and sentinel popped from the
// result side, in order, against a predictor of the index builder. The
// sender works in random bursts, the receiver stalls on its own pattern, and
// max_repeats is changed between phases while the block is drained.
// ---------------------------------------------------------------------------
module tb_sorted_key_run_index_builder_unit;
	import skrib_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS   = 8;

	typedef struct packed {
		logic              has_record;
		logic [WORD_W-1:0] seed;
		logic [WORD_W-1:0] payload;
		logic              eop;
	} part_item_t;

	logic              clk;
	logic              arst_n           = 1'b0;
	logic              push             = 1'b0;
	logic              full;
	logic              has_record       = 1'b0;
	logic [WORD_W-1:0] seed             = '0;
	logic [WORD_W-1:0] payload          = '0;
	logic              end_of_partition = 1'b0;
	logic              empty;
	logic              pop              = 1'b0;
	logic [1:0]        kind;
	logic [WORD_W-1:0] key_or_seed;
	logic [WORD_W-1:0] offset;
	logic [WORD_W-1:0] record_payload;
	logic [WORD_W-1:0] kept_keys;
	logic [WORD_W-1:0] dropped_runs;
	logic              last_of_burst;
	logic              cfg_wr_en        = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data      = '0;

	part_item_t record_q[$];
	res_t       index_q[$];
	int         items_queued = 0;
	int         mismatches   = 0;

	// Predictor state: the open run and the partition totals.
	logic [CFG_W-1:0]  max_rep = MAX_REPEATS_RST;
	logic [WORD_W-1:0] run_key = '0;
	int                run_len = 0;
	bit                run_live = 1'b0;
	bit                run_over = 1'b0;
	logic [WORD_W-1:0] run_buf [MAX_RUN_DEF];
	logic [WORD_W-1:0] rec_total  = '0;
	logic [WORD_W-1:0] key_total  = '0;
	logic [WORD_W-1:0] drop_total = '0;

	int send_burst = 0;
	int send_gap   = 0;
	int rx_left    = 0;
	bit rx_on      = 1'b0;

	sorted_key_run_index_builder_unit u_dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.has_record,
		.seed,
		.payload,
		.end_of_partition,
		.empty,
		.pop,
		.kind,
		.key_or_seed,
		.offset,
		.record_payload,
		.kept_keys,
		.dropped_runs,
		.last_of_burst,
		.cfg_wr_en,
		.cfg_wr_data
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void emit_result(kind_t k, logic [WORD_W-1:0] ks, logic [WORD_W-1:0] off,
			logic [WORD_W-1:0] pl, logic [WORD_W-1:0] kk, logic [WORD_W-1:0] dr);
		res_t r;
		r.kind           = k;
		r.key_or_seed    = ks;
		r.offset         = off;
		r.record_payload = pl;
		r.kept_keys      = kk;
		r.dropped_runs   = dr;
		r.last_of_burst  = 1'b0;
		index_q.push_back(r);
	endfunction

	// A kept run yields its key and then its buffered records; an overlong
	// run only bumps the drop count.
	function automatic void close_open_run();
		if (!run_live)
			return;
		if (run_over) begin
			drop_total = drop_total + 1;
		end else begin
			emit_result(KIND_KEY, run_key, rec_total, '0, '0, '0);
			for (int i = 0; i < run_len; i++)
				emit_result(KIND_RECORD, run_key, '0, run_buf[i], '0, '0);
			key_total = key_total + 1;
			rec_total = rec_total + run_len;
		end
		run_live = 1'b0;
		run_over = 1'b0;
		run_len  = 0;
	endfunction

	function automatic void build_index_entries(part_item_t it);
		int   first;
		int   lim;
		res_t tail;
		first = index_q.size();
		lim   = (max_rep > MAX_RUN_DEF) ? MAX_RUN_DEF : int'(max_rep);
		if (it.has_record) begin
			if (run_live && it.seed != run_key)
				close_open_run();
			if (!run_live) begin
				run_live = 1'b1;
				run_key  = it.seed;
				run_len  = 0;
				run_over = 1'b0;
			end
			if (!run_over) begin
				if (run_len + 1 > lim || run_len >= MAX_RUN_DEF) begin
					run_over = 1'b1;
				end else begin
					run_buf[run_len] = it.payload;
					run_len++;
				end
			end
		end
		if (it.eop) begin
			close_open_run();
			emit_result(KIND_SENTINEL, '0, rec_total, '0, key_total, drop_total);
			rec_total  = '0;
			key_total  = '0;
			drop_total = '0;
		end
		if (index_q.size() > first) begin
			tail = index_q.pop_back();
			tail.last_of_burst = 1'b1;
			index_q.push_back(tail);
		end
	endfunction

	function automatic void check_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic add_item(input bit has, input logic [WORD_W-1:0] s,
			input logic [WORD_W-1:0] pl, input bit eop);
		part_item_t it;
		it.has_record = has;
		it.seed       = s;
		it.payload    = pl;
		it.eop        = eop;
		record_q.push_back(it);
		items_queued++;
	endtask

	// One partition of n_runs runs. Sorted seeds unless scrambled, in which
	// case seeds hop around a small set and come back. With at_limits the
	// first two runs sit just above and at the current limit.
	task automatic add_partition(input int n_runs, input bit scramble, input bit at_limits);
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] s;
		int                lim;
		int                len;
		bit                eop_on_record;
		lim           = (max_rep > MAX_RUN_DEF) ? MAX_RUN_DEF : int'(max_rep);
		base          = $urandom;
		s             = base;
		eop_on_record = (n_runs > 0) && ($urandom_range(0, 1) == 1);
		for (int r = 0; r < n_runs; r++) begin
			if (at_limits && r == 0)
				len = lim + 1;
			else if (at_limits && r == 1)
				len = (lim == 0) ? 1 : lim;
			else
				case ($urandom_range(0, 39))
					0: len = lim + 1;
					1: len = (lim == 0) ? 1 : lim;
					2: len = MAX_RUN_DEF + 1;
					default: len = $urandom_range(1, 3);
				endcase
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 9) == 0)
					add_item(1'b0, $urandom, $urandom, 1'b0);
				add_item(1'b1, s, $urandom, eop_on_record && r == n_runs - 1 && j == len - 1);
			end
			s = scramble ? base + $urandom_range(0, 3) : s + $urandom_range(1, 4096);
		end
		if (!eop_on_record)
			add_item(1'b0, $urandom, $urandom, 1'b1);
	endtask

	// Holds off until every queued transaction is taken and every result has
	// come back, then gives the block time to finish any silent work.
	task automatic settle();
		while (record_q.size() != 0 || index_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: bursts of random length, random gaps, holds while full.
	always @(posedge clk or negedge arst_n) begin
		bit         next_push;
		part_item_t head;
		if (!arst_n) begin
			push             <= 1'b0;
			has_record       <= 1'b0;
			seed             <= '0;
			payload          <= '0;
			end_of_partition <= 1'b0;
			send_burst = 0;
			send_gap   = 0;
		end else begin
			if (push && !full)
				build_index_entries(record_q.pop_front());
			next_push = 1'b0;
			if (push && full) begin
				next_push = 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
			end else if (record_q.size() != 0) begin
				next_push = 1'b1;
				if (send_burst > 1) begin
					send_burst--;
				end else begin
					send_burst = $urandom_range(1, 12);
					send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			push <= next_push;
			if (next_push) begin
				head = record_q[0];
				has_record       <= head.has_record;
				seed             <= head.seed;
				payload          <= head.payload;
				end_of_partition <= head.eop;
			end
		end
	end

	// Receiver: alternates pop stretches with stalls of random length.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			rx_left = 0;
			rx_on   = 1'b0;
		end else begin
			if (pop && !empty) begin
				if (index_q.size() == 0) begin
					$error("result with no transaction pending: kind %0d, key_or_seed 0x%08h",
						kind, key_or_seed);
					mismatches++;
				end else begin
					want = index_q.pop_front();
					check_field("kind", want.kind, kind);
					check_field("key_or_seed", want.key_or_seed, key_or_seed);
					check_field("offset", want.offset, offset);
					check_field("record_payload", want.record_payload, record_payload);
					check_field("kept_keys", want.kept_keys, kept_keys);
					check_field("dropped_runs", want.dropped_runs, dropped_runs);
					check_field("last_of_burst", want.last_of_burst, last_of_burst);
				end
			end
			if (rx_left == 0) begin
				rx_on   = ($urandom_range(0, 2) != 0);
				rx_left = rx_on ? $urandom_range(1, 24) : $urandom_range(1, 6);
			end
			rx_left--;
			pop <= rx_on;
		end
	end

	initial begin
		logic [CFG_W-1:0] setting;
		int               target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 9; p++) begin
			if (p == 0) begin
				// Empty partition, idle item, field extremes, record with the
				// end marker, unsorted seeds, back-to-back end markers.
				add_item(1'b0, '0, '0, 1'b1);
				add_item(1'b0, '1, '1, 1'b0);
				add_item(1'b1, '0, '0, 1'b0);
				add_item(1'b1, '0, '1, 1'b0);
				add_item(1'b1, '1, 32'hA5A5_A5A5, 1'b1);
				add_item(1'b1, 32'd10, 32'd1, 1'b0);
				add_item(1'b1, 32'd5, 32'd2, 1'b0);
				add_item(1'b1, 32'd10, 32'd3, 1'b0);
				add_item(1'b0, '1, '0, 1'b1);
				add_item(1'b0, '0, '1, 1'b1);
				add_item(1'b1, 32'd7, 32'h5A5A_5A5A, 1'b1);
			end else begin
				settle();
				case (p)
					1: setting = 6'd0;
					2: setting = 6'd1;
					3: setting = 6'd63;
					4: setting = 6'd5;
					5: setting = 6'd32;
					6: setting = 6'd2;
					7: setting = 6'd40;
					default: setting = CFG_W'($urandom_range(0, 63));
				endcase
				@(posedge clk);
				cfg_wr_en   <= 1'b1;
				cfg_wr_data <= setting;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				max_rep = setting;
			end
			// Runs just above and at the limit, once for each distinct limit of the fixed settings.
			if ((p >= 1 && p <= 4) || p == 6)
				add_partition(2, 1'b0, 1'b1);
			target = items_queued + PHASE_ITEMS;
			while (items_queued < target)
				add_partition($urandom_range(0, 5), $urandom_range(0, 7) == 0, 1'b0);
		end
		settle();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/skrib_pkg.sv
sv/skrib_ram.sv
sv/skrib_fifo.sv
sv/skrib_front.sv
sv/skrib_back.sv
sv/sorted_key_run_index_builder_unit.sv
sv/skrib_checker.sv
sim/tb_sorted_key_run_index_builder_unit.sv
